FILE: src/midpoint_line_rasterizer_defines.svh
// Assertion macros for the line rasteriser.
`ifndef MIDPOINT_LINE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_DEFINES_SVH

// Overlapping implication, checked out of reset.
`define MLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication, consequent checked in the cycle after, out of reset.
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mlr_pkg.sv
package mlr_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int PIX_BITS           = 13;
    localparam int COLOR_BITS         = 24;
    localparam int STEP_BITS          = 4;
    localparam logic [STEP_BITS-1:0] STEP_MIN   = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_MAX   = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 4'd1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        OCT_ENE = 3'd0,
        OCT_NNE = 3'd1,
        OCT_NNW = 3'd2,
        OCT_WNW = 3'd3,
        OCT_WSW = 3'd4,
        OCT_SSW = 3'd5,
        OCT_SSE = 3'd6,
        OCT_ESE = 3'd7
    } octant_t;

    // Entries {m0, m1, m2, m3}: x = m0*u + m1*v, y = m2*u + m3*v.
    localparam logic signed [1:0] MIRROR_MAP [8][4] = '{
        '{ 2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{-2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0},
        '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1}
    };

    // One term of the mirror product: pass, negate or drop.
    function automatic logic signed [31:0] mirror_term(
        input logic signed [1:0]  m,
        input logic signed [31:0] v
    );
        logic signed [31:0] r;
        if (m == 2'sd1)
        begin
            r = v;
        end
        else if (m == -2'sd1)
        begin
            r = -v;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage

FILE: src/mlr_in_if.sv
interface mlr_in_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
);
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [COORD_BITS-1:0]        start_x;
    logic signed [COORD_BITS-1:0]        start_y;
    logic signed [COORD_BITS-1:0]        end_x;
    logic signed [COORD_BITS-1:0]        end_y;
    logic [mlr_pkg::COLOR_BITS-1:0]      color_in;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, color_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, color_in,
        output ready
    );
endinterface

FILE: src/mlr_out_if.sv
interface mlr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mlr_pkg::PIX_BITS-1:0] pixel_x;
    logic signed [mlr_pkg::PIX_BITS-1:0] pixel_y;
    logic [mlr_pkg::COLOR_BITS-1:0]      pixel_color;
    logic                                last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last,
        output ready
    );
endinterface

FILE: src/midpoint_line_rasterizer.sv
// Midpoint line rasteriser, all eight octants.
// in_ch carries transactions of two kinds. A load (opcode OP_LOAD) gives two
// endpoints and a colour; it yields no pixel and replaces any line in progress.
// A step (opcode OP_STEP) yields one pixel of the active line on out_ch, with
// last set on the pixel that ends the line. The first step yields the start
// point. A step with no active line, and any step after a point-sized load,
// yields nothing.
// step_size is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. It is
// captured with each load that gives a line (0 acts as 1, above 8 as 8).
// A transaction accepted into the input register passes through combinational
// setup or step logic, and its pixel is then held in the output register.
// Throughput: one transaction per cycle unless a pixel stalls on out_ch.ready.
// Stall: the output register holds its pixel while out_ch.ready is low; a load
// or a step with nothing to emit still drains, and the input register takes a
// new transaction whenever its content moves on.
// Reset: no line is active, both registers are empty and step_size returns to 1.
`include "midpoint_line_rasterizer_defines.svh"

module midpoint_line_rasterizer #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mlr_pkg::STEP_BITS-1:0] cfg_wdata,
    mlr_in_if.sink                        in_ch,
    mlr_out_if.source                     out_ch
);
    localparam int P = COORD_BITS + 2;
    localparam int D = COORD_BITS + 6;

    // Configuration
    logic [mlr_pkg::STEP_BITS-1:0] step_size_reg;

    // Input register
    logic                             in_valid_reg;
    logic                             in_op_reg;
    logic signed [COORD_BITS-1:0]     sx_reg, sy_reg, ex_reg, ey_reg;
    logic [mlr_pkg::COLOR_BITS-1:0]   color_reg;

    // Line state
    logic                             active_reg;
    logic                             first_pending_reg;
    mlr_pkg::octant_t                 octant_reg;
    logic [mlr_pkg::STEP_BITS-1:0]    step_held_reg;
    logic signed [P-1:0]              major_pos_reg, minor_pos_reg, major_end_reg;
    logic signed [D-1:0]              decision_reg, inc_east_reg, inc_ne_reg;
    logic [mlr_pkg::COLOR_BITS-1:0]   line_color_reg;

    // Output register
    logic                             out_valid_reg;
    logic signed [mlr_pkg::PIX_BITS-1:0] pix_x_reg, pix_y_reg;
    logic [mlr_pkg::COLOR_BITS-1:0]   pix_color_reg;
    logic                             pix_last_reg;

    // Setup results
    logic                             su_ok;
    mlr_pkg::octant_t                 su_octant;
    logic signed [P-1:0]              su_major, su_minor, su_end;
    logic signed [D-1:0]              su_dec, su_inc_e, su_inc_ne;
    logic [mlr_pkg::STEP_BITS-1:0]    su_step;

    // Step results
    logic signed [P-1:0]              st_major, st_minor;
    logic signed [D-1:0]              st_dec;
    logic signed [mlr_pkg::PIX_BITS-1:0] st_x, st_y;
    logic                             st_last;

    logic is_load, is_step, produces, out_free, advance;

    assign is_load  = in_op_reg == mlr_pkg::OP_LOAD;
    assign is_step  = in_op_reg == mlr_pkg::OP_STEP;
    assign produces = is_step && active_reg;
    assign out_free = !out_valid_reg || out_ch.ready;
    // Drain the input register unless its pixel has nowhere to go.
    assign advance  = in_valid_reg && (!produces || out_free);

    assign in_ch.ready        = !in_valid_reg || advance;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pixel_x     = pix_x_reg;
    assign out_ch.pixel_y     = pix_y_reg;
    assign out_ch.pixel_color = pix_color_reg;
    assign out_ch.last        = pix_last_reg;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x       (sx_reg),
        .start_y       (sy_reg),
        .end_x         (ex_reg),
        .end_y         (ey_reg),
        .step_size     (step_size_reg),
        .line_ok       (su_ok),
        .octant        (su_octant),
        .major_start   (su_major),
        .minor_start   (su_minor),
        .major_end     (su_end),
        .decision      (su_dec),
        .inc_east      (su_inc_e),
        .inc_northeast (su_inc_ne),
        .step_held     (su_step)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .first_pending (first_pending_reg),
        .octant        (octant_reg),
        .step_held     (step_held_reg),
        .major_pos     (major_pos_reg),
        .minor_pos     (minor_pos_reg),
        .major_end     (major_end_reg),
        .decision      (decision_reg),
        .inc_east      (inc_east_reg),
        .inc_northeast (inc_ne_reg),
        .major_next    (st_major),
        .minor_next    (st_minor),
        .decision_next (st_dec),
        .pixel_x       (st_x),
        .pixel_y       (st_y),
        .last          (st_last)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg     <= mlr_pkg::STEP_RESET;
            in_valid_reg      <= 1'b0;
            active_reg        <= 1'b0;
            first_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_size_reg <= cfg_wdata;
            end
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance && is_load)
            begin
                active_reg        <= su_ok;
                first_pending_reg <= su_ok;
            end
            else if (advance && produces)
            begin
                active_reg        <= !st_last;
                first_pending_reg <= 1'b0;
            end
            if (advance && produces)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture on the matching handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_op_reg <= in_ch.opcode;
            sx_reg    <= in_ch.start_x;
            sy_reg    <= in_ch.start_y;
            ex_reg    <= in_ch.end_x;
            ey_reg    <= in_ch.end_y;
            color_reg <= in_ch.color_in;
        end
        if (advance && is_load)
        begin
            line_color_reg <= color_reg;
            if (su_ok)
            begin
                octant_reg    <= su_octant;
                step_held_reg <= su_step;
                major_pos_reg <= su_major;
                minor_pos_reg <= su_minor;
                major_end_reg <= su_end;
                decision_reg  <= su_dec;
                inc_east_reg  <= su_inc_e;
                inc_ne_reg    <= su_inc_ne;
            end
        end
        else if (advance && produces)
        begin
            major_pos_reg <= st_major;
            minor_pos_reg <= st_minor;
            decision_reg  <= st_dec;
            pix_x_reg     <= st_x;
            pix_y_reg     <= st_y;
            pix_color_reg <= line_color_reg;
            pix_last_reg  <= st_last;
        end
    end

    `MLR_ASSERT_NOW(a_first_needs_line, clk, rst_n,
        first_pending_reg, active_reg, "first pixel pending with no active line")
    `MLR_ASSERT_NEXT(a_last_ends_line, clk, rst_n,
        advance && produces && st_last, !active_reg, "line still active after last pixel")
    `MLR_ASSERT_NOW(a_no_overwrite, clk, rst_n,
        out_valid_reg && !out_ch.ready, !(advance && produces),
        "pending pixel overwritten")
    `MLR_ASSERT_NOW(a_walk_before_end, clk, rst_n,
        active_reg && !first_pending_reg, major_pos_reg < major_end_reg,
        "active line already past its end")

endmodule

FILE: src/mlr_setup.sv
module mlr_setup #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
    input  logic signed [COORD_BITS-1:0]           start_x,
    input  logic signed [COORD_BITS-1:0]           start_y,
    input  logic signed [COORD_BITS-1:0]           end_x,
    input  logic signed [COORD_BITS-1:0]           end_y,
    input  logic [mlr_pkg::STEP_BITS-1:0]          step_size,
    output logic                                   line_ok,
    output mlr_pkg::octant_t                       octant,
    output logic signed [COORD_BITS+1:0]           major_start,
    output logic signed [COORD_BITS+1:0]           minor_start,
    output logic signed [COORD_BITS+1:0]           major_end,
    output logic signed [COORD_BITS+5:0]           decision,
    output logic signed [COORD_BITS+5:0]           inc_east,
    output logic signed [COORD_BITS+5:0]           inc_northeast,
    output logic [mlr_pkg::STEP_BITS-1:0]          step_held
);
    localparam int P = COORD_BITS + 2;
    localparam int D = COORD_BITS + 6;

    logic signed [P-1:0] sx, sy, ex, ey;
    logic signed [P-1:0] dx, dy, ndx, ndy;
    logic signed [P-1:0] ue, ve, du, dv;
    logic signed [D-1:0] dv_w, du_w, s_mul, dv_x2, dd_x2;
    logic signed [1:0]   m0, m1, m2, m3;

    assign sx  = P'(start_x);
    assign sy  = P'(start_y);
    assign ex  = P'(end_x);
    assign ey  = P'(end_y);
    assign dx  = ex - sx;
    assign dy  = ey - sy;
    assign ndx = -dx;
    assign ndy = -dy;

    // Pick the octant from signs and magnitudes; a point line has none.
    always_comb
    begin
        line_ok = 1'b1;
        octant  = mlr_pkg::OCT_ENE;
        if (dx > 0 && dy >= 0 && dy <= dx)
        begin
            octant = mlr_pkg::OCT_ENE;
        end
        else if (dy > 0 && dx >= 0 && dy > dx)
        begin
            octant = mlr_pkg::OCT_NNE;
        end
        else if (dy > 0 && dx < 0 && dy > ndx)
        begin
            octant = mlr_pkg::OCT_NNW;
        end
        else if (dx < 0 && dy >= 0 && dy <= ndx)
        begin
            octant = mlr_pkg::OCT_WNW;
        end
        else if (dx < 0 && dy < 0 && dy >= dx)
        begin
            octant = mlr_pkg::OCT_WSW;
        end
        else if (dx < 0 && dy < 0 && dy < dx)
        begin
            octant = mlr_pkg::OCT_SSW;
        end
        else if (dy < 0 && dx >= 0 && ndy > dx)
        begin
            octant = mlr_pkg::OCT_SSE;
        end
        else if (dx > 0 && dy < 0 && ndy <= dx)
        begin
            octant = mlr_pkg::OCT_ESE;
        end
        else
        begin
            line_ok = 1'b0;
        end
    end

    assign m0 = mlr_pkg::MIRROR_MAP[octant][0];
    assign m1 = mlr_pkg::MIRROR_MAP[octant][1];
    assign m2 = mlr_pkg::MIRROR_MAP[octant][2];
    assign m3 = mlr_pkg::MIRROR_MAP[octant][3];

    // Fold into the first octant with the transposed map.
    assign major_start = P'(mlr_pkg::mirror_term(m0, 32'(sx)) + mlr_pkg::mirror_term(m2, 32'(sy)));
    assign minor_start = P'(mlr_pkg::mirror_term(m1, 32'(sx)) + mlr_pkg::mirror_term(m3, 32'(sy)));
    assign ue          = P'(mlr_pkg::mirror_term(m0, 32'(ex)) + mlr_pkg::mirror_term(m2, 32'(ey)));
    assign ve          = P'(mlr_pkg::mirror_term(m1, 32'(ex)) + mlr_pkg::mirror_term(m3, 32'(ey)));
    assign major_end   = ue;
    assign du          = ue - major_start;
    assign dv          = ve - minor_start;

    always_comb
    begin
        if (step_size < mlr_pkg::STEP_MIN)
        begin
            step_held = mlr_pkg::STEP_MIN;
        end
        else if (step_size > mlr_pkg::STEP_MAX)
        begin
            step_held = mlr_pkg::STEP_MAX;
        end
        else
        begin
            step_held = step_size;
        end
    end

    assign dv_w          = D'(dv);
    assign du_w          = D'(du);
    assign s_mul         = $signed(D'(step_held));
    assign dv_x2         = dv_w <<< 1;
    assign dd_x2         = (dv_w - du_w) <<< 1;
    assign decision      = dv_x2 - du_w;
    assign inc_east      = D'(dv_x2 * s_mul);
    assign inc_northeast = D'(dd_x2 * s_mul);

endmodule

FILE: src/mlr_step.sv
module mlr_step #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                   first_pending,
    input  mlr_pkg::octant_t                       octant,
    input  logic [mlr_pkg::STEP_BITS-1:0]          step_held,
    input  logic signed [COORD_BITS+1:0]           major_pos,
    input  logic signed [COORD_BITS+1:0]           minor_pos,
    input  logic signed [COORD_BITS+1:0]           major_end,
    input  logic signed [COORD_BITS+5:0]           decision,
    input  logic signed [COORD_BITS+5:0]           inc_east,
    input  logic signed [COORD_BITS+5:0]           inc_northeast,
    output logic signed [COORD_BITS+1:0]           major_next,
    output logic signed [COORD_BITS+1:0]           minor_next,
    output logic signed [COORD_BITS+5:0]           decision_next,
    output logic signed [mlr_pkg::PIX_BITS-1:0]    pixel_x,
    output logic signed [mlr_pkg::PIX_BITS-1:0]    pixel_y,
    output logic                                   last
);
    localparam int P = COORD_BITS + 2;
    localparam int D = COORD_BITS + 6;

    logic signed [P-1:0] s_pos;
    logic                go_east;
    logic signed [31:0]  px, py;

    assign s_pos   = $signed(P'(step_held));
    assign go_east = decision[D-1] || (decision == '0);

    // Hold the start point on the first step; advance otherwise.
    always_comb
    begin
        major_next    = major_pos;
        minor_next    = minor_pos;
        decision_next = decision;
        if (!first_pending)
        begin
            major_next = major_pos + s_pos;
            if (go_east)
            begin
                decision_next = decision + inc_east;
            end
            else
            begin
                decision_next = decision + inc_northeast;
                minor_next    = minor_pos + s_pos;
            end
        end
    end

    // Map back to the original octant and wrap to the pixel width.
    assign px = mlr_pkg::mirror_term(mlr_pkg::MIRROR_MAP[octant][0], 32'(major_next))
              + mlr_pkg::mirror_term(mlr_pkg::MIRROR_MAP[octant][1], 32'(minor_next));
    assign py = mlr_pkg::mirror_term(mlr_pkg::MIRROR_MAP[octant][2], 32'(major_next))
              + mlr_pkg::mirror_term(mlr_pkg::MIRROR_MAP[octant][3], 32'(minor_next));
    assign pixel_x = px[mlr_pkg::PIX_BITS-1:0];
    assign pixel_y = py[mlr_pkg::PIX_BITS-1:0];
    assign last    = major_next >= major_end;

endmodule
